// ===== hdl/afba_pkg.sv =====
// Package for the aligned free block allocator: sizes, command codes and the
// control/status structs between controller and datapath. No dependencies.
`default_nettype none

package afba_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [ADDR_W-1:0] FAIL_ADDR = {ADDR_W{1'b1}};

    // request modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_ALLOC  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    // table write data select
    localparam logic [1:0] WR_APPEND = 2'd0;
    localparam logic [1:0] WR_BIG    = 2'd1;
    localparam logic [1:0] WR_ALLOC  = 2'd2;
    localparam logic [1:0] WR_MOVE   = 2'd3;

    // entry count operation
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_CLR  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;
    localparam logic [1:0] CNT_DEC  = 2'd3;

    // result address select
    localparam logic [1:0] RA_ZERO = 2'd0;
    localparam logic [1:0] RA_FAIL = 2'd1;
    localparam logic [1:0] RA_SEL  = 2'd2;

    typedef struct packed {
        logic             load;
        logic             scan_init;
        logic             scan_eval;
        logic [IDX_W-1:0] scan_idx;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [1:0]       wr_sel;
        logic [1:0]       cnt_op;
        logic             sel_pick;
        logic             sel_big;
        logic             res_load;
        logic [1:0]       res_status;
        logic [1:0]       res_addr_sel;
        logic             out_load;
    } afba_cmd_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic             flen_zero;
        logic             full;
        logic [CNT_W-1:0] count;
        logic             hit1;
        logic             hit2;
        logic             rest_zero;
        logic             newlen_zero;
        logic [IDX_W-1:0] sel_idx;
        logic [IDX_W-1:0] big_idx;
    } afba_stat_t;

endpackage

`default_nettype wire

// ===== hdl/afba_if.sv =====
// Request and response channel interfaces of the allocator.
// Depends on afba_pkg for field widths.
`default_nettype none

interface afba_req_if import afba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [ADDR_W-1:0] free_base;
    logic [ADDR_W-1:0] free_length;
    logic [ADDR_W-1:0] request_bytes;
    logic [4:0]        align_log2;

    modport source (output valid, mode, free_base, free_length, request_bytes, align_log2,
                    input ready);
    modport sink   (input valid, mode, free_base, free_length, request_bytes, align_log2,
                    output ready);
endinterface

interface afba_rsp_if import afba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;

    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/afba_datapath.sv =====
// Datapath of the allocator: block table memory, entry count, scan compare
// logic, split/shrink arithmetic and the result registers. Uses afba_pkg.
`default_nettype none

module afba_datapath
    import afba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire afba_cmd_t         cmd,
    output afba_stat_t             stat,
    input  wire logic [1:0]        mode,
    input  wire logic [ADDR_W-1:0] free_base,
    input  wire logic [ADDR_W-1:0] free_length,
    input  wire logic [ADDR_W-1:0] request_bytes,
    input  wire logic [4:0]        align_log2,
    output logic [ADDR_W-1:0]      granted_address,
    output logic [1:0]             status
);

    logic [ADDR_W-1:0] base_mem [MAX_BLOCKS];
    logic [ADDR_W-1:0] len_mem  [MAX_BLOCKS];
    logic [ADDR_W-1:0] rd_base_reg;
    logic [ADDR_W-1:0] rd_len_reg;

    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] fbase_reg;
    logic [ADDR_W-1:0] flen_reg;
    logic [ADDR_W:0]   size_reg;
    logic [ADDR_W:0]   align_reg;
    logic [ADDR_W-1:0] amask_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              hit1_reg;
    logic [IDX_W-1:0]  pick_idx_reg;
    logic [ADDR_W-1:0] pick_base_reg;
    logic [ADDR_W-1:0] pick_len_reg;
    logic              hit2_reg;
    logic [IDX_W-1:0]  big_idx_reg;
    logic [ADDR_W-1:0] big_base_reg;
    logic [ADDR_W-1:0] big_len_reg;
    logic [ADDR_W-1:0] big_mis_reg;
    logic              rest_zero_reg;

    logic [ADDR_W-1:0] sel_base_reg;
    logic [ADDR_W-1:0] sel_len_reg;
    logic [IDX_W-1:0]  sel_idx_reg;

    logic [ADDR_W-1:0] res_addr_reg;
    logic [1:0]        res_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [1:0]        out_status_reg;

    // request decode
    logic [ADDR_W-PAGE_SHIFT:0] page_num;
    logic [ADDR_W:0]            size_next;
    logic [ADDR_W:0]            align_next;

    // scan compare
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W:0]   mis;
    logic              aligned;
    logic              fit1;
    logic              fit2;

    // shrink
    logic [ADDR_W-1:0] alloc_base;
    logic [ADDR_W-1:0] alloc_len;

    logic [ADDR_W-1:0] wr_base;
    logic [ADDR_W-1:0] wr_len;

    always_comb
    begin
        page_num   = {1'b0, request_bytes[ADDR_W-1:PAGE_SHIFT]}
                   + {{(ADDR_W-PAGE_SHIFT){1'b0}}, |request_bytes[PAGE_SHIFT-1:0]};
        size_next  = {page_num, {PAGE_SHIFT{1'b0}}};
        align_next = {{ADDR_W{1'b0}}, 1'b1} << align_log2;
    end

    always_comb
    begin
        offset  = rd_base_reg & amask_reg;
        aligned = (offset == '0);
        mis     = align_reg - {1'b0, offset};
        fit1    = ({1'b0, rd_len_reg} >= size_reg);
        fit2    = ({2'b00, rd_len_reg} >= ({1'b0, size_reg} + {1'b0, mis}));
    end

    always_comb
    begin
        alloc_base = sel_base_reg + size_reg[ADDR_W-1:0];
        alloc_len  = sel_len_reg - size_reg[ADDR_W-1:0];
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_APPEND:
            begin
                wr_base = fbase_reg;
                wr_len  = flen_reg;
            end
            WR_BIG:
            begin
                wr_base = big_base_reg;
                wr_len  = big_mis_reg;
            end
            WR_ALLOC:
            begin
                wr_base = alloc_base;
                wr_len  = alloc_len;
            end
            default:
            begin
                wr_base = rd_base_reg;
                wr_len  = rd_len_reg;
            end
        endcase
    end

    // block table, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            base_mem[cmd.wr_addr] <= wr_base;
            len_mem[cmd.wr_addr]  <= wr_len;
        end
        if (cmd.rd_en)
        begin
            rd_base_reg <= base_mem[cmd.rd_addr];
            rd_len_reg  <= len_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hit1_reg  <= 1'b0;
            hit2_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.cnt_op)
                CNT_CLR: count_reg <= '0;
                CNT_INC: count_reg <= count_reg + 1'b1;
                CNT_DEC: count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
            if (cmd.scan_init)
            begin
                hit1_reg <= 1'b0;
                hit2_reg <= 1'b0;
            end
            else if (cmd.scan_eval)
            begin
                if (aligned && fit1)
                begin
                    hit1_reg <= 1'b1;
                end
                if (fit2)
                begin
                    hit2_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            fbase_reg <= free_base;
            flen_reg  <= free_length;
            size_reg  <= size_next;
            align_reg <= align_next;
            amask_reg <= align_next[ADDR_W-1:0] - 1'b1;
        end
        // keep only the first hit of each kind
        if (cmd.scan_eval && !hit1_reg && aligned && fit1)
        begin
            pick_idx_reg  <= cmd.scan_idx;
            pick_base_reg <= rd_base_reg;
            pick_len_reg  <= rd_len_reg;
        end
        if (cmd.scan_eval && !hit2_reg && fit2)
        begin
            big_idx_reg   <= cmd.scan_idx;
            big_base_reg  <= rd_base_reg;
            big_len_reg   <= rd_len_reg;
            big_mis_reg   <= mis[ADDR_W-1:0];
            rest_zero_reg <= ({1'b0, rd_len_reg} == mis);
        end
        if (cmd.sel_pick)
        begin
            sel_base_reg <= pick_base_reg;
            sel_len_reg  <= pick_len_reg;
            sel_idx_reg  <= pick_idx_reg;
        end
        else if (cmd.sel_big)
        begin
            sel_base_reg <= big_base_reg + big_mis_reg;
            sel_len_reg  <= big_len_reg - big_mis_reg;
            sel_idx_reg  <= count_reg[IDX_W-1:0];
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_addr_sel)
                RA_FAIL: res_addr_reg <= FAIL_ADDR;
                RA_SEL:  res_addr_reg <= sel_base_reg;
                default: res_addr_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        stat.mode        = mode_reg;
        stat.flen_zero   = (flen_reg == '0);
        stat.full        = (count_reg >= CNT_W'(MAX_BLOCKS));
        stat.count       = count_reg;
        stat.hit1        = hit1_reg;
        stat.hit2        = hit2_reg;
        stat.rest_zero   = rest_zero_reg;
        stat.newlen_zero = !size_reg[ADDR_W] && (sel_len_reg == size_reg[ADDR_W-1:0]);
        stat.sel_idx     = sel_idx_reg;
        stat.big_idx     = big_idx_reg;
    end

    assign granted_address = out_addr_reg;
    assign status          = out_status_reg;

endmodule

`default_nettype wire

// ===== hdl/afba_controller.sv =====
// Controller of the allocator: sequences decode, table scan, split, shrink
// and delete shift, and owns the handshakes. Uses afba_pkg.
`default_nettype none

module afba_controller
    import afba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output afba_cmd_t       cmd,
    input  wire afba_stat_t stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             split_reg;
    logic             split_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [CNT_W:0]   idx_p1;
    logic [CNT_W:0]   idx_p2;
    logic [CNT_W:0]   sel_p1;
    logic [CNT_W:0]   count_ext;

    always_comb
    begin
        idx_p1    = {{(CNT_W+1-IDX_W){1'b0}}, idx_reg} + 1'b1;
        idx_p2    = {{(CNT_W+1-IDX_W){1'b0}}, idx_reg} + 2'd2;
        sel_p1    = {{(CNT_W+1-IDX_W){1'b0}}, stat.sel_idx} + 1'b1;
        count_ext = {1'b0, stat.count};
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        split_next     = split_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        req_ready      = (state_reg == S_IDLE);

        cmd              = '0;
        cmd.scan_idx     = idx_reg;
        cmd.wr_sel       = WR_MOVE;
        cmd.cnt_op       = CNT_HOLD;
        cmd.res_status   = ST_OK;
        cmd.res_addr_sel = RA_ZERO;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
                case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    MODE_APPEND:
                    begin
                        if (stat.flen_zero)
                        begin
                            cmd.res_status = ST_ZERO;
                        end
                        else if (stat.full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = stat.count[IDX_W-1:0];
                            cmd.wr_sel  = WR_APPEND;
                            cmd.cnt_op  = CNT_INC;
                        end
                    end
                    MODE_ALLOC:
                    begin
                        cmd.res_load  = 1'b0;
                        cmd.scan_init = 1'b1;
                        idx_next      = '0;
                        if (stat.count == '0)
                        begin
                            state_next = S_DECIDE;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_eval = 1'b1;
                if (idx_p1 < count_ext)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_p1[IDX_W-1:0];
                    idx_next    = idx_p1[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.hit1)
                begin
                    cmd.sel_pick = 1'b1;
                    split_next   = 1'b0;
                    state_next   = S_FIN;
                end
                else if (!stat.hit2 || stat.rest_zero)
                begin
                    cmd.res_load     = 1'b1;
                    cmd.res_status   = ST_NOFIT;
                    cmd.res_addr_sel = RA_FAIL;
                    state_next       = S_RESP;
                end
                else if (stat.full)
                begin
                    cmd.res_load     = 1'b1;
                    cmd.res_status   = ST_FULL;
                    cmd.res_addr_sel = RA_FAIL;
                    state_next       = S_RESP;
                end
                else
                begin
                    // lower part keeps only the misalignment gap
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = stat.big_idx;
                    cmd.wr_sel  = WR_BIG;
                    cmd.sel_big = 1'b1;
                    split_next  = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.res_load     = 1'b1;
                cmd.res_status   = ST_OK;
                cmd.res_addr_sel = RA_SEL;
                state_next       = S_RESP;
                if (!stat.newlen_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = stat.sel_idx;
                    cmd.wr_sel  = WR_ALLOC;
                    if (split_reg)
                    begin
                        cmd.cnt_op = CNT_INC;
                    end
                end
                else if (!split_reg)
                begin
                    // entry emptied: shift the entries above it down
                    idx_next = stat.sel_idx;
                    if (sel_p1 < count_ext)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = sel_p1[IDX_W-1:0];
                        state_next  = S_SHIFT;
                    end
                    else
                    begin
                        cmd.cnt_op = CNT_DEC;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_reg;
                cmd.wr_sel  = WR_MOVE;
                if (idx_p2 < count_ext)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_p2[IDX_W-1:0];
                    idx_next    = idx_p1[IDX_W-1:0];
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            split_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            split_reg     <= split_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= CNT_W'(MAX_BLOCKS))
        else $error("entry count above table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> {1'b0, idx_reg} < count_ext)
        else $error("scan index beyond valid entries");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> idx_p1 < count_ext)
        else $error("delete shift reads beyond valid entries");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == S_DECODE)
        else $error("accepted beat not decoded");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || rsp_ready)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== hdl/aligned_free_block_allocator.sv =====
// Aligned free block allocator: a free block table of MAX_BLOCKS entries
// with clear, append and first-fit aligned allocate commands.
// Requests arrive on the req channel; one beat on rsp answers each request.
// Mode 0 clears the table, mode 1 appends a free block (base, length),
// mode 2 allocates request_bytes rounded up to 4 KiB pages at an alignment
// of 2^align_log2. The answer carries the granted base (all ones on a failed allocation)
// and a status: ok, no fitting block, table full, or zero-length append.
// Clear and append pass from the request registers through the result
// register to the response register. An allocation scans the table once,
// one entry per cycle through the single table read port, and when an
// emptied entry is deleted, the entries above it are moved down one by one.
// One request is in work at a time; the next is accepted as soon as the
// current one has moved to the response register.
// Reset clears the entry count and the control state; the table contents
// are not cleared and only entries below the count are ever read.
// When the receiver stalls, the response beat holds in its register, one
// more request may be accepted and worked, and its answer waits until the
// held beat is taken.
`default_nettype none

module aligned_free_block_allocator
    import afba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    afba_req_if.sink  req,
    afba_rsp_if.source rsp
);

    afba_cmd_t  cmd;
    afba_stat_t stat;

    afba_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    afba_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .mode            (req.mode),
        .free_base       (req.free_base),
        .free_length     (req.free_length),
        .request_bytes   (req.request_bytes),
        .align_log2      (req.align_log2),
        .granted_address (rsp.granted_address),
        .status          (rsp.status)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_aligned_free_block_allocator.sv =====
// Self-checking bench for aligned_free_block_allocator: drives clear, append and
// allocate requests, predicts every answer from a shadow free block table.
// Depends on afba_pkg and the afba_req_if / afba_rsp_if channel interfaces.
`default_nettype none

module tb_aligned_free_block_allocator;
    import afba_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_CMDS = 1425;
    localparam int TAIL_CYCLES = 2 * MAX_BLOCKS + 10;

    typedef struct {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] req_bytes;
        logic [4:0]        align;
        bit                drain_first;
    } alloc_cmd_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
    } alloc_answer_t;

    logic clk;
    logic rst_n;

    afba_req_if req_ch();
    afba_rsp_if rsp_ch();

    aligned_free_block_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the free block table
    logic [ADDR_W-1:0] blk_base [MAX_BLOCKS];
    logic [ADDR_W-1:0] blk_len  [MAX_BLOCKS];
    int                blk_count;

    alloc_cmd_t    cmd_queue[$];
    alloc_answer_t pending_answers[$];
    alloc_cmd_t    drv_cmd;
    alloc_answer_t seen_answer;

    int  total_cmds;
    int  accepted_cmds;
    int  answer_count;
    int  mismatch_count;
    int  cycle_count;
    int  gap_left;
    int  stall_left;
    bit  req_took;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic alloc_cmd_t make_cmd(logic [1:0] mode, logic [31:0] base,
                                            logic [31:0] length, logic [31:0] req_bytes,
                                            logic [4:0] align);
        alloc_cmd_t c;
        c.mode        = mode;
        c.base        = base;
        c.length      = length;
        c.req_bytes   = req_bytes;
        c.align       = align;
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic alloc_cmd_t random_cmd();
        alloc_cmd_t c;
        int r;
        c = make_cmd(MODE_ALLOC, $urandom, $urandom, $urandom, 5'($urandom_range(0, 31)));
        r = $urandom_range(0, 99);
        if (r < 4)
            c.mode = MODE_CLEAR;
        else if (r < 6)
            c.mode = MODE_SPARE;
        else if (r < 42)
        begin
            c.mode = MODE_APPEND;
            if ($urandom_range(0, 9) != 0)
                c.base = c.base & ~32'hfff;
            r = $urandom_range(0, 14);
            if (r == 0)
                c.length = '0;
            else if (r > 1)
                c.length = $urandom_range(1, 64) << PAGE_SHIFT;
        end
        else
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                c.req_bytes = '0;
            else if (r > 1)
                c.req_bytes = $urandom_range(1, 32'h2_0000);
            if ($urandom_range(0, 4) != 0)
                c.align = 5'($urandom_range(12, 17));
        end
        return c;
    endfunction

    // Apply one request to the shadow table and return the answer it earns.
    function automatic alloc_answer_t table_apply(alloc_cmd_t c);
        alloc_answer_t a;
        logic [63:0]   size;
        logic [63:0]   align;
        logic [63:0]   amask;
        logic [63:0]   mis;
        logic [63:0]   m;
        logic [63:0]   rest;
        int            pick;
        int            big;
        int            i;
        a.addr   = '0;
        a.status = ST_OK;
        case (c.mode)
            MODE_CLEAR:
                blk_count = 0;
            MODE_APPEND:
                if (c.length == '0)
                    a.status = ST_ZERO;
                else if (blk_count >= MAX_BLOCKS)
                    a.status = ST_FULL;
                else
                begin
                    blk_base[blk_count] = c.base;
                    blk_len[blk_count]  = c.length;
                    blk_count++;
                end
            MODE_ALLOC:
            begin
                size  = (64'(c.req_bytes) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES)
                        * 64'(PAGE_BYTES);
                align = 64'd1 << c.align;
                amask = align - 64'd1;
                pick  = -1;
                for (i = 0; i < blk_count; i++)
                    if (pick < 0 && (64'(blk_base[i]) & amask) == 64'd0
                        && 64'(blk_len[i]) >= size)
                        pick = i;
                if (pick < 0)
                begin
                    // an aligned base still counts a whole alignment unit
                    big = -1;
                    mis = '0;
                    for (i = 0; i < blk_count; i++)
                    begin
                        m = align - (64'(blk_base[i]) & amask);
                        if (big < 0 && 64'(blk_len[i]) >= size + m)
                        begin
                            big = i;
                            mis = m;
                        end
                    end
                    if (big >= 0)
                        rest = 64'(blk_len[big]) - mis;
                    if (big < 0 || rest == 64'd0)
                    begin
                        a.addr   = FAIL_ADDR;
                        a.status = ST_NOFIT;
                    end
                    else if (blk_count >= MAX_BLOCKS)
                    begin
                        a.addr   = FAIL_ADDR;
                        a.status = ST_FULL;
                    end
                    else
                    begin
                        pick           = blk_count;
                        blk_base[pick] = blk_base[big] + mis[31:0];
                        blk_len[pick]  = rest[31:0];
                        blk_len[big]   = mis[31:0];
                        blk_count++;
                    end
                end
                if (pick >= 0)
                begin
                    a.addr         = blk_base[pick];
                    blk_base[pick] = blk_base[pick] + size[31:0];
                    blk_len[pick]  = blk_len[pick] - size[31:0];
                    if (blk_len[pick] == '0)
                    begin
                        for (i = pick; i < blk_count - 1; i++)
                        begin
                            blk_base[i] = blk_base[i + 1];
                            blk_len[i]  = blk_len[i + 1];
                        end
                        blk_count--;
                    end
                end
            end
            default:
                ;
        endcase
        return a;
    endfunction

    // request side: present beats at the falling edge, hold until taken
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_took))
        begin
            if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end
            else if (cmd_queue.size() > 0
                     && (!cmd_queue[0].drain_first || pending_answers.size() == 0))
            begin
                drv_cmd               = cmd_queue.pop_front();
                req_ch.mode          <= drv_cmd.mode;
                req_ch.free_base     <= drv_cmd.base;
                req_ch.free_length   <= drv_cmd.length;
                req_ch.request_bytes <= drv_cmd.req_bytes;
                req_ch.align_log2    <= drv_cmd.align;
                req_ch.valid         <= 1'b1;
                // every fourth stretch of 100 beats runs back to back
                gap_left <= ((accepted_cmds / 100) % 4 == 3) ? 0 : pick_gap();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        req_took <= req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            pending_answers.push_back(table_apply(make_cmd(req_ch.mode, req_ch.free_base,
                                                           req_ch.free_length,
                                                           req_ch.request_bytes,
                                                           req_ch.align_log2)));
            accepted_cmds++;
        end
    end

    // response side: random back-pressure, with calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ((cycle_count / 2000) % 3 != 2 && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            answer_count++;
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("answer %0d unexpected: addr %h status %0d",
                             answer_count, rsp_ch.granted_address, rsp_ch.status);
            end
            else
            begin
                seen_answer = pending_answers.pop_front();
                if (rsp_ch.granted_address !== seen_answer.addr
                    || rsp_ch.status !== seen_answer.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("answer %0d: expected addr %h status %0d, got addr %h status %0d",
                                 answer_count, seen_answer.addr, seen_answer.status,
                                 rsp_ch.granted_address, rsp_ch.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        alloc_cmd_t c;
        int         n;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_CLEAR;
        req_ch.free_base     = '0;
        req_ch.free_length   = '0;
        req_ch.request_bytes = '0;
        req_ch.align_log2    = '0;
        rsp_ch.ready         = 1'b0;
        req_took             = 1'b0;
        gap_left             = 0;
        stall_left           = 0;
        blk_count            = 0;
        accepted_cmds        = 0;
        answer_count         = 0;
        mismatch_count       = 0;
        cycle_count          = 0;

        // wrap on split and on shrink, then the delete that moves an entry down
        cmd_queue.push_back(make_cmd(MODE_CLEAR,  '0, '0, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'hffff_f000, 32'h3000, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'h1000, 5'd31));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'h1000, 5'd0));
        // rounded size past 32 bits
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'hffff_f001, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '1, '1, 32'hffff_ffff, 5'd31));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'h0001_1000, 32'h1000, '0, 5'd0));
        // zero request: split leaving an empty part, then an aligned hit
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, '0, 5'd13));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, '0, 5'd12));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'hffff_ffff, 32'hffff_ffff, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, '0, 32'h1, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'h0010_0000, 32'h0010_0000, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'h0020_0000, 32'h8000, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'h0030_0800, 32'h0004_0000, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'h0050_0000, 32'h1000, '0, 5'd0));
        // table full, then zero length on a full table
        cmd_queue.push_back(make_cmd(MODE_APPEND, 32'h0060_0000, 32'h1000, '0, 5'd0));
        cmd_queue.push_back(make_cmd(MODE_APPEND, '0, '0, '0, 5'd0));
        // split needed with no free slot
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'h1000, 5'd22));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'h1000, 5'd20));
        cmd_queue.push_back(make_cmd(MODE_SPARE,  '1, '1, '1, 5'd31));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'h7fff_ffff, 5'd31));
        cmd_queue.push_back(make_cmd(MODE_ALLOC,  '0, '0, 32'h2_0000, 5'd12));
        cmd_queue.push_back(make_cmd(MODE_CLEAR,  '1, '1, '1, 5'd31));
        cmd_queue.push_back(make_cmd(MODE_SPARE,  '0, '0, '0, 5'd0));

        n = 0;
        while (n < RANDOM_CMDS)
        begin
            c = random_cmd();
            // hold off until the block has answered everything
            c.drain_first = (n == 0) || (n % 317 == 0);
            if (c.mode != MODE_SPARE)
                n++;
            cmd_queue.push_back(c);
        end
        total_cmds = cmd_queue.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cmds < total_cmds || pending_answers.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== aligned_free_block_allocator.f =====
hdl/afba_pkg.sv
hdl/afba_if.sv
hdl/afba_datapath.sv
hdl/afba_controller.sv
hdl/aligned_free_block_allocator.sv
tb/sv/tb_aligned_free_block_allocator.sv
